### rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// Line box clip package
// Register indexes of the box corner registers and configuration port sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

  localparam int NUM_BOX_REGS = 6;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Z = 3'd5;

endpackage

`default_nettype wire

### rtl/line_box_clip_test_3d.sv
// Throughput: one segment per cycle while the output is not stalled; three axis
// stages, three exact ratio compares of two stages each and one quantiser stage per
// result bit make up the pipeline.
// A result beat held on the output stalls the whole pipeline, losing nothing.
// Reset clears the pipeline valid bits and sets all six box corner registers to zero.
// ----------------------------------------------------------------------------
// Line box clip test, 3D
// Tests a segment against the configured axis-aligned box and reports the
// hit flag with the entry and exit parameters in unsigned fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_box_clip_test_3d #(
  parameter int COORD_BITS      = 32,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [lbc_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  wire logic [COORD_BITS-1:0]                   cfg_data_i,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, zero padding
  input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // hit, enter_param, exit_param, zero padding
  output logic [((2*PARAM_FRAC_BITS+10)/8)*8-1:0]      m_axis_tdata
);

  import lbc_pkg::*;

  localparam int N     = COORD_BITS;
  localparam int W     = COORD_BITS + 1;
  localparam int QW    = PARAM_FRAC_BITS + 1;
  localparam int LAT   = PARAM_FRAC_BITS + 10;
  localparam int OUT_W = ((2*PARAM_FRAC_BITS+10)/8)*8;

  logic [N-1:0]   box_q [NUM_BOX_REGS];
  logic [LAT-1:0] vld_q;
  logic           adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BOX_REGS; i++) begin
        box_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MIN_X: box_q[REG_MIN_X] <= cfg_data_i;
        REG_MIN_Y: box_q[REG_MIN_Y] <= cfg_data_i;
        REG_MIN_Z: box_q[REG_MIN_Z] <= cfg_data_i;
        REG_MAX_X: box_q[REG_MAX_X] <= cfg_data_i;
        REG_MAX_Y: box_q[REG_MAX_Y] <= cfg_data_i;
        REG_MAX_Z: box_q[REG_MAX_Z] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  logic [2:0][W-1:0] en_n, en_d, ex_n, ex_d;
  logic [2:0]        ax_rej;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    lbc_axis #(.N(N)) u_axis (
      .clk_i    (clk_i),
      .en_i     (adv),
      .start_i  (s_axis_tdata[k*N +: N]),
      .end_i    (s_axis_tdata[(k+3)*N +: N]),
      .lo_i     (box_q[k]),
      .hi_i     (box_q[k+3]),
      .en_num_o (en_n[k]),
      .en_den_o (en_d[k]),
      .ex_num_o (ex_n[k]),
      .ex_den_o (ex_d[k]),
      .rej_o    (ax_rej[k])
    );
  end

  // First level: x against y for both the entry maximum and the exit minimum.
  logic              gt1e, gt1x;
  logic [11:0][W-1:0] v1_d, v1_q;
  logic              rej1_q;

  lbc_cmp #(.W(W)) u_c1e (
    .clk_i(clk_i), .en_i(adv), .an_i(en_n[0]), .ad_i(en_d[0]),
    .bn_i(en_n[1]), .bd_i(en_d[1]), .gt_o(gt1e)
  );
  lbc_cmp #(.W(W)) u_c1x (
    .clk_i(clk_i), .en_i(adv), .an_i(ex_n[0]), .ad_i(ex_d[0]),
    .bn_i(ex_n[1]), .bd_i(ex_d[1]), .gt_o(gt1x)
  );

  assign v1_d = {en_n[0], en_d[0], en_n[1], en_d[1], en_n[2], en_d[2],
                 ex_n[0], ex_d[0], ex_n[1], ex_d[1], ex_n[2], ex_d[2]};

  lbc_dly #(.WD(12*W+1), .DEPTH(2)) u_d1 (
    .clk_i(clk_i), .en_i(adv), .d_i({|ax_rej, v1_d}), .q_o({rej1_q, v1_q})
  );

  logic [W-1:0] lxy_n, lxy_d, uxy_n, uxy_d;

  assign lxy_n = gt1e ? v1_q[11] : v1_q[9];
  assign lxy_d = gt1e ? v1_q[10] : v1_q[8];
  assign uxy_n = gt1x ? v1_q[3]  : v1_q[5];
  assign uxy_d = gt1x ? v1_q[2]  : v1_q[4];

  // Second level: the x-y winners against z.
  logic              gt2e, gt2x;
  logic [7:0][W-1:0] v2_q;
  logic              rej2_q;

  lbc_cmp #(.W(W)) u_c2e (
    .clk_i(clk_i), .en_i(adv), .an_i(lxy_n), .ad_i(lxy_d),
    .bn_i(v1_q[7]), .bd_i(v1_q[6]), .gt_o(gt2e)
  );
  lbc_cmp #(.W(W)) u_c2x (
    .clk_i(clk_i), .en_i(adv), .an_i(uxy_n), .ad_i(uxy_d),
    .bn_i(v1_q[1]), .bd_i(v1_q[0]), .gt_o(gt2x)
  );

  lbc_dly #(.WD(8*W+1), .DEPTH(2)) u_d2 (
    .clk_i(clk_i), .en_i(adv),
    .d_i({rej1_q, lxy_n, lxy_d, uxy_n, uxy_d, v1_q[7], v1_q[6], v1_q[1], v1_q[0]}),
    .q_o({rej2_q, v2_q})
  );

  logic [W-1:0] l_n, l_d, u_n, u_d;

  assign l_n = gt2e ? v2_q[7] : v2_q[3];
  assign l_d = gt2e ? v2_q[6] : v2_q[2];
  assign u_n = gt2x ? v2_q[1] : v2_q[5];
  assign u_d = gt2x ? v2_q[0] : v2_q[4];

  // Third level: an entry beyond the exit rejects the segment.
  logic              gt3;
  logic [3:0][W-1:0] v3_q;
  logic              rej3_q, rejf;

  lbc_cmp #(.W(W)) u_c3 (
    .clk_i(clk_i), .en_i(adv), .an_i(l_n), .ad_i(l_d),
    .bn_i(u_n), .bd_i(u_d), .gt_o(gt3)
  );

  lbc_dly #(.WD(4*W+1), .DEPTH(2)) u_d3 (
    .clk_i(clk_i), .en_i(adv), .d_i({rej2_q, l_n, l_d, u_n, u_d}),
    .q_o({rej3_q, v3_q})
  );

  assign rejf = rej3_q || gt3;

  logic [PARAM_FRAC_BITS+1:0][1:0][W:0]    q_rem;
  logic [PARAM_FRAC_BITS+1:0][1:0][W-1:0]  q_den;
  logic [PARAM_FRAC_BITS+1:0][1:0][QW-1:0] q_res;
  logic [PARAM_FRAC_BITS+1:0]              q_hit;

  assign q_rem[0][0] = rejf ? '0 : {1'b0, v3_q[3]};
  assign q_den[0][0] = rejf ? W'(1) : v3_q[2];
  assign q_rem[0][1] = rejf ? '0 : {1'b0, v3_q[1]};
  assign q_den[0][1] = rejf ? W'(1) : v3_q[0];
  assign q_res[0]    = '0;
  assign q_hit[0]    = !rejf;

  for (genvar g = 0; g < QW; g++) begin : g_quant
    lbc_qstep #(.W(W), .RW(QW), .FIRST(g == 0)) u_step (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (q_rem[g]),
      .den_i (q_den[g]),
      .res_i (q_res[g]),
      .hit_i (q_hit[g]),
      .rem_o (q_rem[g+1]),
      .den_o (q_den[g+1]),
      .res_o (q_res[g+1]),
      .hit_o (q_hit[g+1])
    );
  end

  assign m_axis_tdata = OUT_W'({q_res[QW][1], q_res[QW][0], q_hit[QW]});

endmodule

`default_nettype wire

### rtl/lbc_dly.sv
// ----------------------------------------------------------------------------
// Line box clip payload delay
// Carries side data alongside a multi-cycle unit, advancing with the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_dly #(
  parameter int WD    = 8,
  parameter int DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [WD-1:0] d_i,
  output logic      [WD-1:0] q_o
);

  logic [WD-1:0] data_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        data_q[i] <= data_q[i-1];
      end
    end
  end

  assign q_o = data_q[DEPTH-1];

endmodule

`default_nettype wire

### rtl/lbc_axis.sv
// ----------------------------------------------------------------------------
// Line box clip axis stage
// Forms the entry and exit ratios of one axis over three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_axis #(
  parameter int N = 32
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic signed [N-1:0] start_i,
  input  wire logic signed [N-1:0] end_i,
  input  wire logic signed [N-1:0] lo_i,
  input  wire logic signed [N-1:0] hi_i,
  output logic             [N:0]   en_num_o,
  output logic             [N:0]   en_den_o,
  output logic             [N:0]   ex_num_o,
  output logic             [N:0]   ex_den_o,
  output logic                     rej_o
);

  logic signed [N:0] s_x, e_x, lo_x, hi_x;
  logic              swap;
  logic signed [N:0] d_q, a1_q, a2_q;

  logic              dneg, dz, dpos;
  logic        [N:0] dmag_d, dmag_q;
  logic signed [N:0] enr_d, exr_d, enr_q, exr_q;
  logic              prej_d, prej_q, dz_q;

  logic              en_big, ex_big;
  logic        [N:0] en_num_q, en_den_q, ex_num_q, ex_den_q;
  logic              rej_q;

  assign swap = lo_i > hi_i;
  assign s_x  = {start_i[N-1], start_i};
  assign e_x  = {end_i[N-1], end_i};
  assign lo_x = swap ? {hi_i[N-1], hi_i} : {lo_i[N-1], lo_i};
  assign hi_x = swap ? {lo_i[N-1], lo_i} : {hi_i[N-1], hi_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q  <= e_x - s_x;
      a1_q <= lo_x - s_x;
      a2_q <= hi_x - s_x;
    end
  end

  assign dneg   = d_q[N];
  assign dz     = (d_q == '0);
  assign dpos   = !dneg && !dz;
  assign dmag_d = dneg ? -d_q : d_q;
  assign enr_d  = dpos ? a1_q : -a2_q;
  assign exr_d  = dpos ? a2_q : -a1_q;
  assign prej_d = dz && ((!a1_q[N] && (a1_q != '0)) || a2_q[N]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q <= dmag_d;
      enr_q  <= enr_d;
      exr_q  <= exr_d;
      dz_q   <= dz;
      prej_q <= prej_d;
    end
  end

  assign en_big = $signed({enr_q[N], enr_q}) > $signed({1'b0, dmag_q});
  assign ex_big = $signed({exr_q[N], exr_q}) > $signed({1'b0, dmag_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (dz_q) begin
        en_num_q <= '0;
        en_den_q <= (N+1)'(1);
        ex_num_q <= (N+1)'(1);
        ex_den_q <= (N+1)'(1);
        rej_q    <= prej_q;
      end else begin
        en_num_q <= enr_q[N] ? '0 : enr_q;
        en_den_q <= enr_q[N] ? (N+1)'(1) : dmag_q;
        ex_num_q <= ex_big ? (N+1)'(1) : exr_q;
        ex_den_q <= ex_big ? (N+1)'(1) : dmag_q;
        rej_q    <= en_big || exr_q[N];
      end
    end
  end

  assign en_num_o = en_num_q;
  assign en_den_o = en_den_q;
  assign ex_num_o = ex_num_q;
  assign ex_den_o = ex_den_q;
  assign rej_o    = rej_q;

endmodule

`default_nettype wire

### rtl/lbc_cmp.sv
// ----------------------------------------------------------------------------
// Line box clip ratio comparator
// Exact test of an/ad > bn/bd by cross products split into half-width parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_cmp #(
  parameter int W = 33
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] an_i,
  input  wire logic [W-1:0] ad_i,
  input  wire logic [W-1:0] bn_i,
  input  wire logic [W-1:0] bd_i,
  output logic              gt_o
);

  localparam int H = (W + 1) / 2;
  localparam int G = W - H;

  logic [2*G-1:0] p_hh_q, q_hh_q;
  logic [G+H-1:0] p_hl_q, p_lh_q, q_hl_q, q_lh_q;
  logic [2*H-1:0] p_ll_q, q_ll_q;
  logic [2*W-1:0] prod_p, prod_q;
  logic           gt_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_hh_q <= an_i[W-1:H] * bd_i[W-1:H];
      p_hl_q <= an_i[W-1:H] * bd_i[H-1:0];
      p_lh_q <= an_i[H-1:0] * bd_i[W-1:H];
      p_ll_q <= an_i[H-1:0] * bd_i[H-1:0];
      q_hh_q <= bn_i[W-1:H] * ad_i[W-1:H];
      q_hl_q <= bn_i[W-1:H] * ad_i[H-1:0];
      q_lh_q <= bn_i[H-1:0] * ad_i[W-1:H];
      q_ll_q <= bn_i[H-1:0] * ad_i[H-1:0];
    end
  end

  assign prod_p = ((2*W)'(p_hh_q) << (2*H)) + ((2*W)'(p_hl_q) << H)
                + ((2*W)'(p_lh_q) << H) + (2*W)'(p_ll_q);
  assign prod_q = ((2*W)'(q_hh_q) << (2*H)) + ((2*W)'(q_hl_q) << H)
                + ((2*W)'(q_lh_q) << H) + (2*W)'(q_ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gt_q <= prod_p > prod_q;
    end
  end

  assign gt_o = gt_q;

endmodule

`default_nettype wire

### rtl/lbc_qstep.sv
// ----------------------------------------------------------------------------
// Line box clip quantiser step
// One restoring division step for the entry and exit lanes, one bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_qstep #(
  parameter int W     = 33,
  parameter int RW    = 17,
  parameter bit FIRST = 1'b0
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [1:0][W:0]       rem_i,
  input  wire logic [1:0][W-1:0]     den_i,
  input  wire logic [1:0][RW-1:0]    res_i,
  input  wire logic                  hit_i,
  output logic      [1:0][W:0]       rem_o,
  output logic      [1:0][W-1:0]     den_o,
  output logic      [1:0][RW-1:0]    res_o,
  output logic                       hit_o
);

  logic [1:0][W:0]    sh, rem_d;
  logic [1:0]         ge;
  logic [1:0][W:0]    rem_q;
  logic [1:0][W-1:0]  den_q;
  logic [1:0][RW-1:0] res_q;
  logic               hit_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sh[l]    = FIRST ? rem_i[l] : {rem_i[l][W-1:0], 1'b0};
      ge[l]    = sh[l] >= {1'b0, den_i[l]};
      rem_d[l] = ge[l] ? sh[l] - {1'b0, den_i[l]} : sh[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_d[l];
        den_q[l] <= den_i[l];
        res_q[l] <= {res_i[l][RW-2:0], ge[l]};
      end
      hit_q <= hit_i;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign res_o = res_q;
  assign hit_o = hit_q;

endmodule

`default_nettype wire

### rtl/lbc_checker.sv
// ----------------------------------------------------------------------------
// Line box clip checker
// Watches the stream ports of the clip test and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_checker #(
  parameter int COORD_BITS      = 32,
  parameter int PARAM_FRAC_BITS = 16
) (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   s_axis_tready,
  input wire logic                                   m_axis_tvalid,
  input wire logic                                   m_axis_tready,
  input wire logic [((2*PARAM_FRAC_BITS+10)/8)*8-1:0] m_axis_tdata
);

  localparam int QW = PARAM_FRAC_BITS + 1;

  logic          hit;
  logic [QW-1:0] enter_p, exit_p;

  assign hit     = m_axis_tdata[0];
  assign enter_p = m_axis_tdata[QW:1];
  assign exit_p  = m_axis_tdata[2*QW:QW+1];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the pipeline is stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hit |-> enter_p == '0 && exit_p == '0)
    else $error("rejected segment with nonzero parameters");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && hit |-> enter_p <= exit_p && exit_p <= (QW'(1) << PARAM_FRAC_BITS))
    else $error("entry beyond exit or exit beyond one");

endmodule

bind line_box_clip_test_3d lbc_checker #(
  .COORD_BITS      (COORD_BITS),
  .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
) u_lbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
